>>> rtl/window_3x3_filter_assert.svh
// Assertion macros shared by the window filter modules.
// Each module that asserts has ports clk_i and rst_ni.
`ifndef WINDOW_3X3_FILTER_ASSERT_SVH
`define WINDOW_3X3_FILTER_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define WF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define WF3_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/wf3_pkg.sv
// Types and constants of the 3x3 window filter.
// Used by the front, queue, back and top level; depends on nothing.
package wf3_pkg;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } wf3_cfg_idx_e;

  typedef enum logic {
    MODE_BOX     = 1'b0,
    MODE_LAPLACE = 1'b1
  } wf3_mode_e;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int SUM_W   = 12;
  localparam int LAP_W   = 11;

  // floor(sum / 9) as (sum * 7282) >> 16, exact for sums up to 9 * 255
  localparam logic [12:0] BOX_RECIP = 13'd7282;
  localparam int          BOX_SHIFT = 16;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [ROW_W-1:0] last_row;
    wf3_mode_e        mode;
  } wf3_cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]        sum;
    logic signed [LAP_W-1:0] lap;
    wf3_mode_e               mode;
    logic                    frame_end;
  } wf3_entry_t;

endpackage

>>> rtl/wf3_front.sv
// Front end: position tracking, line store memory and 3x3 window.
// Produces partial sums for interior pixels; uses wf3_pkg and the assert header.
`include "window_3x3_filter_assert.svh"

module wf3_front
  import wf3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic              frame_start_i,
  input  logic [CW-1:0]     last_col_i,
  input  wf3_cfg_t          cfg_i,
  output logic              busy_o,
  output logic              q_push_o,
  output wf3_entry_t        q_data_o
);

  logic [CW-1:0]    col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;

  logic             s1_valid_q;
  logic [CW-1:0]    s1_col_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_emit_q;
  logic             s1_fend_q;

  logic [2*PIX_W-1:0] line_mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] byp_data_q;
  logic               byp_q;
  logic [2*PIX_W-1:0] line_word;
  logic [2*PIX_W-1:0] wr_data;

  logic [PIX_W-1:0] win_q [6];
  logic [PIX_W-1:0] win [9];

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    if (col_cur >= last_col_i) begin
      col_d = '0;
      row_d = (row_cur >= cfg_i.last_row) ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_d = col_cur + CW'(1);
      row_d = row_cur;
    end
  end

  // [15:8] row above, [7:0] two rows above
  assign line_word = byp_q ? byp_data_q : rd_q;
  assign wr_data   = {s1_pix_q, line_word[2*PIX_W-1:PIX_W]};

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q <= line_mem_q[col_cur];
    end
    if (s1_valid_q) begin
      line_mem_q[s1_col_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      s1_valid_q <= accept_i;
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        byp_q <= s1_valid_q && (s1_col_q == col_cur);
      end
      if (s1_valid_q) begin
        for (int i = 0; i < 6; i++) win_q[i] <= win[i+3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_col_q   <= col_cur;
      s1_pix_q   <= pixel_i;
      s1_emit_q  <= (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
      s1_fend_q  <= (row_cur == cfg_i.last_row) && (col_cur == last_col_i);
      byp_data_q <= wr_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) win[i] = win_q[i];
    win[6] = line_word[PIX_W-1:0];
    win[7] = line_word[2*PIX_W-1:PIX_W];
    win[8] = s1_pix_q;
  end

  always_comb begin
    q_data_o.sum = '0;
    for (int i = 0; i < 9; i++) q_data_o.sum = q_data_o.sum + SUM_W'(win[i]);
    q_data_o.lap = $signed({1'b0, win[4], 2'b00})
                 - $signed(LAP_W'(win[3])) - $signed(LAP_W'(win[5]))
                 - $signed(LAP_W'(win[1])) - $signed(LAP_W'(win[7]));
    q_data_o.mode      = cfg_i.mode;
    q_data_o.frame_end = s1_fend_q;
  end

  assign q_push_o = s1_valid_q && s1_emit_q;
  assign busy_o   = s1_valid_q;

  `WF3_ASSERT_IMPL(a_byp_same_addr, byp_q && s1_valid_q, $past(s1_col_q) == s1_col_q,
    "line store bypass taken for a different address")
  `WF3_ASSERT_IMPL(a_fend_wraps, q_push_o && q_data_o.frame_end,
    col_q == '0 && row_q == '0, "frame end without position wrap")

endmodule

>>> rtl/wf3_queue.sv
// Short queue between front and back, carrying partial results.
// Reports full early enough to cover the item still in the front; uses wf3_pkg.
`include "window_3x3_filter_assert.svh"

module wf3_queue
  import wf3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  wf3_entry_t data_i,
  input  logic       inflight_i,
  input  logic       pop_i,
  output wf3_entry_t data_o,
  output logic       empty_o,
  output logic       full_o
);

  wf3_entry_t     entries_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q;
  logic [QCW-1:0] level;

  assign level   = count_q + QCW'(inflight_i);
  assign full_o  = level >= QCW'(QDEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QAW'(1);
      count_q <= count_q + QCW'(push_i) - QCW'(pop_i);
    end
  end

  `WF3_ASSERT(a_no_overflow, !(push_i && !pop_i && count_q == QCW'(QDEPTH)),
    "queue overflow")
  `WF3_ASSERT_IMPL(a_no_underflow, pop_i, !empty_o, "queue underflow")

endmodule

>>> rtl/wf3_back.sv
// Back end: divide by nine or halve and saturate, into the result register.
// Uses wf3_pkg; pops the queue whenever the result register is free.
module wf3_back
  import wf3_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wf3_entry_t       q_data_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             pop,
  output logic             empty,
  output logic [PIX_W-1:0] filtered_value_o,
  output logic             frame_end_o
);

  logic             valid_q;
  logic [PIX_W-1:0] value_q, value_d;
  logic             fend_q;
  logic [24:0]      prod;
  logic [LAP_W-2:0] half;

  assign q_pop_o = !q_empty_i && (!valid_q || pop);

  always_comb begin
    prod = 25'(q_data_i.sum) * 25'(BOX_RECIP);
    half = q_data_i.lap[LAP_W-1:1];
    value_d = prod[BOX_SHIFT +: PIX_W];
    if (q_data_i.mode == MODE_LAPLACE) begin
      if (q_data_i.lap[LAP_W-1]) begin
        value_d = '0;
      end else if (half > (LAP_W-1)'(255)) begin
        value_d = '1;
      end else begin
        value_d = half[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      value_q <= value_d;
      fend_q  <= q_data_i.frame_end;
    end
  end

  assign empty            = !valid_q;
  assign filtered_value_o = value_q;
  assign frame_end_o      = fend_q;

endmodule

>>> rtl/window_3x3_filter.sv
// 3x3 window filter, top level: configuration registers and the three stages.
// Depends on wf3_pkg, wf3_front, wf3_queue and wf3_back.
//
// Takes one 8-bit pixel per clock in raster order while not full, and gives
// one result per clock while popped for each interior pixel (box average over
// 9 or half Laplacian saturated to 0..255): a WxH frame gives (W-2)x(H-2)
// items, the last marked by frame_end_o. The line store is one dual-row memory
// of MAX_WIDTH words read and written once per item and needs no clearing
// after reset; a four-entry queue lets the output stall without stopping the
// input until it fills.
module window_3x3_filter
  import wf3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             frame_start_i,
  output logic             empty,
  input  logic             pop,
  output logic [PIX_W-1:0] filtered_value_o,
  output logic             frame_end_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [11:0]      cfg_data_i
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RstWidth   = 640;
  localparam int LastColRst = (RstWidth > MAX_WIDTH) ? MAX_WIDTH - 1 : RstWidth - 1;

  logic [CW-1:0] last_col_q, last_col_d;
  wf3_cfg_t      cfg_q;
  logic          accept;
  logic          busy;
  logic          q_push, q_pop, q_empty;
  wf3_entry_t    q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_comb begin
    if (cfg_data_i < 12'd3) begin
      last_col_d = CW'(2);
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      last_col_d = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_d = CW'(cfg_data_i - 12'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q     <= CW'(LastColRst);
      cfg_q.last_row <= ROW_W'(479);
      cfg_q.mode     <= MODE_BOX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WIDTH:  last_col_q <= last_col_d;
        CFG_HEIGHT: cfg_q.last_row <= (cfg_data_i < 12'd3) ? ROW_W'(2)
                                                           : cfg_data_i - 12'd1;
        CFG_MODE:   cfg_q.mode <= wf3_mode_e'(cfg_data_i[0]);
        default:    ;
      endcase
    end
  end

  wf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .last_col_i    (last_col_q),
    .cfg_i         (cfg_q),
    .busy_o        (busy),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  wf3_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .data_i     (q_wdata),
    .inflight_i (busy),
    .pop_i      (q_pop),
    .data_o     (q_rdata),
    .empty_o    (q_empty),
    .full_o     (full)
  );

  wf3_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_data_i         (q_rdata),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .pop              (pop),
    .empty            (empty),
    .filtered_value_o (filtered_value_o),
    .frame_end_o      (frame_end_o)
  );

endmodule
